// File: hw/rtl/linear_elastic_pk2_stress_assert.svh
// Assertion macros used by the checker file of this block.
// Each macro is used on a line of its own and expects clk and rst_n in scope.
`ifndef LINEAR_ELASTIC_PK2_STRESS_ASSERT_SVH
`define LINEAR_ELASTIC_PK2_STRESS_ASSERT_SVH
`define LEPK2_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lepk2: same-cycle check failed");
`define LEPK2_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lepk2: next-cycle check failed");
`endif

// File: hw/rtl/lepk2_pkg.sv
`default_nettype none
package lepk2_pkg;

  localparam int GRAD_W  = 32;
  localparam int NGRAD   = 9;
  localparam int PROD_W  = 2 * GRAD_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int C_DROP  = 36;
  localparam int CG_W    = SUM_W - C_DROP;
  localparam int PAIR_W  = CG_W + 1;
  localparam int COEF_W  = 32;
  localparam int ACC_W   = 64;
  localparam int S_DROP  = 20;
  localparam int RND_W   = ACC_W - S_DROP;
  localparam int OUT_W   = 32;
  localparam int NOUT    = 6;
  localparam int ADDR_W  = 4;

  localparam logic [1:0] REG_COEF_NORMAL = 2'd0;
  localparam logic [1:0] REG_COEF_CROSS  = 2'd1;
  localparam logic [1:0] REG_COEF_SHEAR  = 2'd2;

  localparam logic signed [SUM_W-1:0] C_ROUND = SUM_W'(1) <<< (C_DROP - 1);
  localparam logic signed [ACC_W-1:0] S_ROUND = ACC_W'(1) <<< (S_DROP - 1);

  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(2147483647);
  localparam logic signed [RND_W-1:0] SAT_LO = -RND_W'(64'sd2147483648);

  // Drops the low 20 fraction bits of a Q.36 sum that already carries its rounding
  // half, then clamps to the signed 32-bit range.
  function automatic logic [OUT_W-1:0] sat_q16(input logic signed [ACC_W-1:0] acc);
    logic signed [RND_W-1:0] r;
    r = acc[ACC_W-1:S_DROP];
    if (r > SAT_HI) begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end else if (r < SAT_LO) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end
    return r[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/linear_elastic_pk2_stress.sv
`default_nettype none
// Second Piola-Kirchhoff stress of a St Venant-Kirchhoff material. Each input
// transfer carries one 3x3 deformation gradient in Q4.28; each output transfer
// carries the six independent stress entries in saturated Q16.16. The block
// takes one gradient per clock while its first stage is free to advance, and
// passes it through five register stages: eighteen 32x32 products,
// rounding of the Cauchy-Green sums, pairing of the diagonal terms, the
// coefficient products, and rounding with saturation into the output
// register. A stall on the output holds each stage that has no free slot
// below it, so bubbles are squeezed out. The coefficients are written
// through the configuration port and must only change while the block is idle.
module linear_elastic_pk2_stress (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // grad_00, grad_01, grad_02, grad_10, grad_11, grad_12, grad_20, grad_21,
  // grad_22, 32 bits each, from the lowest bit up.
  input  wire logic [lepk2_pkg::NGRAD*lepk2_pkg::GRAD_W-1:0] in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // stress_xx, stress_yy, stress_zz, stress_xy, stress_yz, stress_xz,
  // 32 bits each, from the lowest bit up.
  output logic [lepk2_pkg::NOUT*lepk2_pkg::OUT_W-1:0] out_tdata,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [lepk2_pkg::ADDR_W-1:0]      cfg_paddr,
  input  wire logic [31:0]                       cfg_pwdata,
  output logic [31:0]                            cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int GW = lepk2_pkg::GRAD_W;
  localparam int PW = lepk2_pkg::PROD_W;
  localparam int SW = lepk2_pkg::SUM_W;
  localparam int CW = lepk2_pkg::CG_W;
  localparam int QW = lepk2_pkg::PAIR_W;
  localparam int KW = lepk2_pkg::COEF_W;
  localparam int AW = lepk2_pkg::ACC_W;
  localparam int OW = lepk2_pkg::OUT_W;

  logic signed [KW-1:0] coef_normal_r, coef_cross_r, coef_shear_r;
  logic                 cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_normal_r <= '0;
      coef_cross_r  <= '0;
      coef_shear_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        lepk2_pkg::REG_COEF_NORMAL: coef_normal_r <= cfg_pwdata;
        lepk2_pkg::REG_COEF_CROSS:  coef_cross_r  <= cfg_pwdata;
        lepk2_pkg::REG_COEF_SHEAR:  coef_shear_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      lepk2_pkg::REG_COEF_NORMAL: cfg_prdata = coef_normal_r;
      lepk2_pkg::REG_COEF_CROSS:  cfg_prdata = coef_cross_r;
      lepk2_pkg::REG_COEF_SHEAR:  cfg_prdata = coef_shear_r;
      default:                    cfg_prdata = '0;
    endcase
  end

  // Stage valid bits and advance enables.
  logic [5:1] v_r;
  logic [5:1] adv;

  always_comb begin
    adv[5] = !v_r[5] || out_tready;
    for (int k = 4; k >= 1; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_tready  = adv[1];
  assign out_tvalid = v_r[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[1]) v_r[1] <= in_tvalid;
      for (int k = 2; k <= 5; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Stage 1: products of the column entries.
  logic signed [GW-1:0] f [3][3];
  logic signed [PW-1:0] pd_r [3][3];
  logic signed [PW-1:0] px_r [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        f[r][c] = in_tdata[(r*3+c)*GW +: GW];
      end
    end
  end

  // Column pairs of the shear terms: xy, yz, xz.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          pd_r[i][r] <= PW'(f[r][i]) * PW'(f[r][i]);
        end
        px_r[0][r] <= PW'(f[r][0]) * PW'(f[r][1]);
        px_r[1][r] <= PW'(f[r][1]) * PW'(f[r][2]);
        px_r[2][r] <= PW'(f[r][0]) * PW'(f[r][2]);
      end
    end
  end

  // Stage 2: exact sums rounded to Q.20.
  logic signed [SW-1:0] sd [3];
  logic signed [SW-1:0] sx [3];
  logic signed [CW-1:0] cd_r [3];
  logic signed [CW-1:0] cx_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sd[i] = SW'(pd_r[i][0]) + SW'(pd_r[i][1]) + SW'(pd_r[i][2]) + lepk2_pkg::C_ROUND;
      sx[i] = SW'(px_r[i][0]) + SW'(px_r[i][1]) + SW'(px_r[i][2]) + lepk2_pkg::C_ROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        cd_r[i] <= sd[i][SW-1:lepk2_pkg::C_DROP];
        cx_r[i] <= sx[i][SW-1:lepk2_pkg::C_DROP];
      end
    end
  end

  // Stage 3: sums of the other two diagonal entries.
  logic signed [CW-1:0] cd3_r [3];
  logic signed [CW-1:0] cx3_r [3];
  logic signed [QW-1:0] pr3_r [3];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < 3; i++) begin
        cd3_r[i] <= cd_r[i];
        cx3_r[i] <= cx_r[i];
      end
      pr3_r[0] <= QW'(cd_r[1]) + QW'(cd_r[2]);
      pr3_r[1] <= QW'(cd_r[0]) + QW'(cd_r[2]);
      pr3_r[2] <= QW'(cd_r[0]) + QW'(cd_r[1]);
    end
  end

  // Stage 4: coefficient products and the constant offset.
  logic signed [AW-1:0] mn_r [3];
  logic signed [AW-1:0] mx_r [3];
  logic signed [AW-1:0] sh_r [3];
  logic signed [AW-1:0] off_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int i = 0; i < 3; i++) begin
        mn_r[i] <= AW'(coef_normal_r) * AW'(cd3_r[i]);
        mx_r[i] <= AW'(coef_cross_r) * AW'(pr3_r[i]);
        sh_r[i] <= AW'(coef_shear_r) * AW'(cx3_r[i]);
      end
      off_r <= ((AW'(coef_normal_r) + (AW'(coef_cross_r) <<< 1)) <<< lepk2_pkg::S_DROP)
               - lepk2_pkg::S_ROUND;
    end
  end

  // Stage 5: rounding and saturation into the output register.
  logic [OW-1:0] res_r [6];

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int i = 0; i < 3; i++) begin
        res_r[i]   <= lepk2_pkg::sat_q16(mn_r[i] + mx_r[i] - off_r);
        res_r[i+3] <= lepk2_pkg::sat_q16(sh_r[i] + lepk2_pkg::S_ROUND);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      out_tdata[i*OW +: OW] = res_r[i];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lepk2_chk.sv
`default_nettype none
`include "linear_elastic_pk2_stress_assert.svh"
module lepk2_chk (
  input wire logic                                          clk,
  input wire logic                                          rst_n,
  input wire logic                                          in_tvalid,
  input wire logic                                          in_tready,
  input wire logic                                          out_tvalid,
  input wire logic                                          out_tready,
  input wire logic [lepk2_pkg::NOUT*lepk2_pkg::OUT_W-1:0]   out_tdata,
  input wire logic                                          cfg_pready
);

  // With the output register empty every stage can move, so input is taken.
  `LEPK2_IMPLIES(a_empty_out_ready, !out_tvalid, in_tready)
  // A ready output side lets the whole pipeline advance.
  `LEPK2_IMPLIES(a_ready_passes, out_tready && cfg_pready, in_tready)
  // An input transfer is delivered when the output side stays ready behind it.
  `LEPK2_NEXT(a_latency, in_tvalid && in_tready ##1 out_tready [*4], out_tvalid)
  // A stalled result is held unchanged.
  `LEPK2_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind linear_elastic_pk2_stress lepk2_chk u_lepk2_chk (.*);
`default_nettype wire

// File: tb/sv/tb_linear_elastic_pk2_stress.sv
`default_nettype none
module tb_linear_elastic_pk2_stress;

  typedef logic [lepk2_pkg::NGRAD-1:0][lepk2_pkg::GRAD_W-1:0] grad_set_t;
  typedef logic [lepk2_pkg::NOUT-1:0][lepk2_pkg::OUT_W-1:0] stress_set_t;
  typedef logic signed [79:0] wide_t;

  localparam int NGRAD = lepk2_pkg::NGRAD;
  localparam int NOUT = lepk2_pkg::NOUT;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam int ITEMS_PER_PHASE = 215;
  localparam int NUM_PHASES = 8;
  localparam int QUIET_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [lepk2_pkg::NGRAD*lepk2_pkg::GRAD_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [lepk2_pkg::NOUT*lepk2_pkg::OUT_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [lepk2_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  linear_elastic_pk2_stress u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  logic signed [31:0] coef_c1 = '0;
  logic signed [31:0] coef_c2 = '0;
  logic signed [31:0] coef_c4 = '0;

  grad_set_t grad_q[$];
  stress_set_t stress_q[$];
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;

  string stress_name[NOUT] = '{"stress_xx", "stress_yy", "stress_zz",
                               "stress_xy", "stress_yz", "stress_xz"};

  // Dot product of two gradient columns, rounded half up from Q.56 to Q.20.
  function automatic wide_t cauchy_green_dot(input logic signed [31:0] a0, b0, a1, b1,
                                             a2, b2);
    wide_t s;
    s = a0 * b0 + a1 * b1 + a2 * b2 + (80'sd1 <<< 35);
    return s >>> 36;
  endfunction

  function automatic logic [31:0] round_saturate(input wide_t acc);
    wide_t r;
    r = (acc + (80'sd1 <<< 19)) >>> 20;
    if (r > 80'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (r < -80'sd2147483648) begin
      return 32'h8000_0000;
    end
    return r[31:0];
  endfunction

  function automatic stress_set_t pk2_stress(input grad_set_t f);
    wide_t c00, c11, c22, c01, c12, c02, c1, c2, c4, offset;
    stress_set_t s;
    c00 = cauchy_green_dot(f[0], f[0], f[3], f[3], f[6], f[6]);
    c11 = cauchy_green_dot(f[1], f[1], f[4], f[4], f[7], f[7]);
    c22 = cauchy_green_dot(f[2], f[2], f[5], f[5], f[8], f[8]);
    c01 = cauchy_green_dot(f[0], f[1], f[3], f[4], f[6], f[7]);
    c12 = cauchy_green_dot(f[1], f[2], f[4], f[5], f[7], f[8]);
    c02 = cauchy_green_dot(f[0], f[2], f[3], f[5], f[6], f[8]);
    c1 = coef_c1;
    c2 = coef_c2;
    c4 = coef_c4;
    offset = (c1 + 2 * c2) <<< 20;
    s[0] = round_saturate(c1 * c00 + c2 * (c11 + c22) - offset);
    s[1] = round_saturate(c1 * c11 + c2 * (c00 + c22) - offset);
    s[2] = round_saturate(c1 * c22 + c2 * (c00 + c11) - offset);
    s[3] = round_saturate(c4 * c01);
    s[4] = round_saturate(c4 * c12);
    s[5] = round_saturate(c4 * c02);
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  // Input transfers: the expected stresses are worked out at acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        stress_q.push_back(pk2_stress(grad_set_t'(in_tdata)));
      end
      if (grad_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_tdata <= grad_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    stress_set_t got;
    stress_set_t want;
    got = stress_set_t'(out_tdata);
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (stress_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_tdata));
        end else begin
          want = stress_q.pop_front();
          for (int k = 0; k < NOUT; k++) begin
            if (got[k] !== want[k]) begin
              report_mismatch($sformatf("%s got %h expected %h", stress_name[k],
                                        got[k], want[k]));
            end
          end
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_coef(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      lepk2_pkg::REG_COEF_NORMAL: coef_c1 = value;
      lepk2_pkg::REG_COEF_CROSS: coef_c2 = value;
      lepk2_pkg::REG_COEF_SHEAR: coef_c4 = value;
      default: ;
    endcase
  endtask

  task automatic write_all_coefs(input logic [31:0] c1, c2, c4);
    write_coef(lepk2_pkg::REG_COEF_NORMAL, c1);
    write_coef(lepk2_pkg::REG_COEF_CROSS, c2);
    write_coef(lepk2_pkg::REG_COEF_SHEAR, c4);
  endtask

  // Waits until every gradient has been sent and every stress set received.
  task automatic drain_pipeline();
    do @(negedge clk); while (grad_q.size() != 0 || in_tvalid || stress_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_corner_gradients();
    grad_set_t f;
    f = '0;
    for (int i = 0; i < NGRAD; i += 4) f[i] = 32'h1000_0000;
    grad_q.push_back(f);
    grad_q.push_back('0);
    for (int i = 0; i < NGRAD; i++) f[i] = 32'h7fff_ffff;
    grad_q.push_back(f);
    for (int i = 0; i < NGRAD; i++) f[i] = 32'h8000_0000;
    grad_q.push_back(f);
    for (int i = 0; i < NGRAD; i++) f[i] = i[0] ? 32'h8000_0000 : 32'h7fff_ffff;
    grad_q.push_back(f);
    // Column 0 sums to exactly half an LSB of the rounded C00.
    f = '0;
    f[0] = 32'h0002_0000;
    f[3] = 32'h0002_0000;
    grad_q.push_back(f);
  endtask

  function automatic grad_set_t random_gradient();
    grad_set_t f;
    int unsigned mode;
    mode = $urandom_range(9);
    for (int i = 0; i < NGRAD; i++) begin
      if (mode <= 3) begin
        f[i] = $urandom();
      end else if (mode <= 7) begin
        f[i] = ((i % 4 == 0) ? 32'h1000_0000 : 32'h0) + $urandom_range(32'h00ff_ffff)
               - 32'h0080_0000;
      end else if (mode == 8) begin
        case ($urandom_range(5))
          0: f[i] = 32'h7fff_ffff;
          1: f[i] = 32'h8000_0000;
          2: f[i] = 32'h0;
          3: f[i] = 32'h1;
          4: f[i] = 32'hffff_ffff;
          default: f[i] = 32'h1000_0000;
        endcase
      end else begin
        f[i] = $signed($urandom()) >>> 2;
      end
    end
    return f;
  endfunction

  task automatic load_random_coefs();
    logic [31:0] c1, c2, c4;
    case ($urandom_range(2))
      0: begin
        c1 = $urandom();
        c2 = $urandom();
        c4 = $urandom();
      end
      1: begin
        c2 = $urandom_range(32'h0100_0000);
        c4 = $urandom_range(32'h0100_0000);
        c1 = c2 + 2 * c4;
      end
      default: begin
        c1 = $signed($urandom()) >>> 4;
        c2 = $signed($urandom()) >>> 4;
        c4 = $signed($urandom()) >>> 4;
      end
    endcase
    write_all_coefs(c1, c2, c4);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    push_corner_gradients();
    drain_pipeline();
    write_all_coefs(32'h0003_0000, 32'h0001_0000, 32'h0000_8000);
    write_coef(REG_UNMAPPED, 32'hffff_ffff);
    push_corner_gradients();
    drain_pipeline();
    write_all_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    push_corner_gradients();
    drain_pipeline();
    write_all_coefs(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    push_corner_gradients();
    drain_pipeline();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 56;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 56;
        end
        default: begin
          idle_pct = 35;
          stall_pct = 35;
        end
      endcase
      if (p == 3) begin
        write_all_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      end else if (p == 6) begin
        write_all_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      end else begin
        load_random_coefs();
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        grad_q.push_back(random_gradient());
        // The sender holds off here until the pipeline has emptied.
        if (p == 1 && n == ITEMS_PER_PHASE / 2) begin
          drain_pipeline();
        end
      end
      drain_pipeline();
    end

    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: linear_elastic_pk2_stress.f
+incdir+hw/rtl
hw/rtl/lepk2_pkg.sv
hw/rtl/linear_elastic_pk2_stress.sv
hw/rtl/lepk2_chk.sv
tb/sv/tb_linear_elastic_pk2_stress.sv
